@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ hw/rtl/sactc_pkg.sv @@
// ----------------------------------------------------------------------------
// sactc_pkg
// Types and constants of the set-associative cache tag controller.
// ----------------------------------------------------------------------------
package sactc_pkg;

    localparam int DEF_MAX_WAYS   = 16;
    localparam int DEF_MAX_SETS   = 256;
    localparam int DEF_ADDR_WIDTH = 48;

    localparam int RANK_W    = 4;
    localparam int RANK_TOP  = 15;
    localparam int WAY_OUT_W = 4;
    localparam int CNT_W     = 32;
    localparam int OFF_LIMIT = 12;
    localparam int SB_LIMIT  = 16;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef enum logic [1:0] {
        REG_POLICY = 2'd0,
        REG_OFFSET = 2'd1,
        REG_SETS   = 2'd2,
        REG_WAYS   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 evicted;
    } lookup_t;

endpackage

@@ hw/rtl/sactc_req_if.sv @@
// ----------------------------------------------------------------------------
// sactc_req_if
// Access request channel: valid/ready with the access word.
// ----------------------------------------------------------------------------
interface sactc_req_if #(
    parameter int ADDR_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic                  is_write;
    logic [ADDR_WIDTH-1:0] address;

    modport source (output valid, is_write, address, input ready);
    modport sink   (input valid, is_write, address, output ready);
endinterface

@@ hw/rtl/sactc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sactc_rsp_if
// Lookup result channel: valid/ready with the result word.
// ----------------------------------------------------------------------------
interface sactc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  way_used;
    logic        evicted;
    logic [31:0] memory_reads;
    logic [31:0] memory_writes;
    logic [31:0] hit_count;
    logic [31:0] miss_count;

    modport source (output valid, hit, way_used, evicted, memory_reads, memory_writes,
                    hit_count, miss_count, input ready);
    modport sink   (input valid, hit, way_used, evicted, memory_reads, memory_writes,
                    hit_count, miss_count, output ready);
endinterface

@@ hw/rtl/sactc_ram.sv @@
// ----------------------------------------------------------------------------
// sactc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sactc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ hw/rtl/sactc_set_logic.sv @@
// ----------------------------------------------------------------------------
// sactc_set_logic
// Tag compare, victim choice and rank update over one set row.
// ----------------------------------------------------------------------------
module sactc_set_logic #(
    parameter int MAX_WAYS   = 16,
    parameter int ADDR_WIDTH = 48,
    parameter int LINE_W     = 1 + ADDR_WIDTH + 4,
    parameter int WCNT_W     = $clog2(MAX_WAYS + 1)
) (
    input  logic [MAX_WAYS*LINE_W-1:0] row_in,
    input  logic [ADDR_WIDTH-1:0]      tag,
    input  logic [WCNT_W-1:0]          ways,
    input  logic                       policy_is_lru,
    output logic [MAX_WAYS*LINE_W-1:0] row_out,
    output sactc_pkg::lookup_t         res
);
    import sactc_pkg::*;

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0]   valid;
    logic [ADDR_WIDTH-1:0] tags  [MAX_WAYS];
    logic [RANK_W-1:0]     ranks [MAX_WAYS];
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   match;
    logic [MAX_WAYS-1:0]   free;
    logic [MAX_WAYS-1:0]   victim;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      vic_way;
    logic [WAY_W-1:0]      way;
    logic                  hit;
    logic                  placed;
    logic                  touch;
    logic [RANK_W:0]       old_rank;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            valid[w]  = row_in[w*LINE_W + LINE_W - 1];
            tags[w]   = row_in[w*LINE_W + RANK_W +: ADDR_WIDTH];
            ranks[w]  = row_in[w*LINE_W +: RANK_W];
            in_use[w] = (w < int'(ways));
            match[w]  = in_use[w] && valid[w] && (tags[w] == tag);
            free[w]   = in_use[w] && !valid[w];
        end
        // way w is the victim when older than all lower ways and no younger than higher ones
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            victim[w] = in_use[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (in_use[v] && v < w && !(ranks[v] < ranks[w]))
                begin
                    victim[w] = 1'b0;
                end
                if (in_use[v] && v > w && (ranks[v] > ranks[w]))
                begin
                    victim[w] = 1'b0;
                end
            end
        end
        hit_way  = '0;
        free_way = '0;
        vic_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (free[w])
            begin
                free_way = WAY_W'(w);
            end
            if (victim[w])
            begin
                vic_way = WAY_W'(w);
            end
        end
        hit    = |match;
        placed = !hit && (|free);
        way    = hit ? hit_way : (placed ? free_way : vic_way);
        touch  = !hit || policy_is_lru;
        old_rank = placed ? (RANK_W+1)'(RANK_TOP + 1) : {1'b0, ranks[way]};

        row_out = row_in;
        if (touch)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (WAY_W'(w) == way)
                begin
                    row_out[w*LINE_W +: RANK_W] = '0;
                    if (!hit)
                    begin
                        row_out[w*LINE_W + LINE_W - 1]       = 1'b1;
                        row_out[w*LINE_W + RANK_W +: ADDR_WIDTH] = tag;
                    end
                end
                else if (in_use[w] && valid[w] && ({1'b0, ranks[w]} < old_rank)
                         && (ranks[w] != RANK_W'(RANK_TOP)))
                begin
                    row_out[w*LINE_W +: RANK_W] = ranks[w] + 1'b1;
                end
            end
        end

        res.hit      = hit;
        res.way_used = WAY_OUT_W'({{WAY_OUT_W{1'b0}}, way});
        res.evicted  = !hit && !placed;
    end
endmodule

@@ hw/rtl/set_assoc_cache_tag_controller.sv @@
// The set row is read from the tag RAM when an access is accepted; the result
// word is registered when the update completes, once the result slot is free.
// A new access is accepted only in the idle state, after the read-modify-write
// of the set row (read at acceptance, compare and write back in S_UPDATE).
// Reset: control and configuration registers return to defaults; the tag RAM
// is then cleared row by row, all DEPTH rows, during which no access is accepted.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag lookup and LRU/FIFO replacement with saturating access counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_cache_tag_controller #(
    parameter int MAX_WAYS   = sactc_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS   = sactc_pkg::DEF_MAX_SETS,
    parameter int ADDR_WIDTH = sactc_pkg::DEF_ADDR_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sactc_req_if.sink                     req,
    sactc_rsp_if.source                   rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sactc_pkg::PADDR_W-1:0] paddr,
    input  logic [sactc_pkg::PDATA_W-1:0] pwdata,
    output logic [sactc_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import sactc_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int DEPTH  = 2 ** SET_W;
    localparam int LINE_W = 1 + ADDR_WIDTH + RANK_W;
    localparam int ROW_W  = MAX_WAYS * LINE_W;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);

    state_t state_reg, state_next;
    logic [SET_W-1:0]      clr_reg;
    logic                  policy_reg;
    logic [3:0]            offset_reg;
    logic [3:0]            sets_reg;
    logic [4:0]            ways_reg;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic                  wr_reg;
    logic [CNT_W-1:0]      reads_reg, writes_reg, hits_reg, misses_reg;
    logic                  rsp_valid_reg;
    lookup_t               res_reg;

    logic                  cfg_wr;
    logic [3:0]            off_eff;
    logic [4:0]            sb_eff;
    logic [ADDR_WIDTH-1:0] shifted;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag_val;
    logic [WCNT_W-1:0]     ways_eff;
    logic                  accept;
    logic                  retire;
    logic                  ram_we;
    logic [SET_W-1:0]      ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic [ROW_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      row_new;
    lookup_t               res;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b1;
            offset_reg <= 4'd4;
            sets_reg   <= 4'd0;
            ways_reg   <= 5'd1;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            unique case (cfg_reg_t'(paddr[3:2]))
                REG_POLICY: policy_reg <= pwdata[0];
                REG_OFFSET: offset_reg <= pwdata[3:0];
                REG_SETS:   sets_reg   <= pwdata[3:0];
                REG_WAYS:   ways_reg   <= pwdata[4:0];
                default:    policy_reg <= policy_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_reg_t'(paddr[3:2]))
            REG_POLICY: prdata = PDATA_W'(policy_reg);
            REG_OFFSET: prdata = PDATA_W'(offset_reg);
            REG_SETS:   prdata = PDATA_W'(sets_reg);
            REG_WAYS:   prdata = PDATA_W'(ways_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- address split ----------------
    always_comb
    begin
        off_eff = (offset_reg > 4'(OFF_LIMIT)) ? 4'(OFF_LIMIT) : offset_reg;
        sb_eff  = 5'(sets_reg);
        if (sb_eff > 5'(SB_LIMIT))
        begin
            sb_eff = 5'(SB_LIMIT);
        end
        shifted = req.address >> off_eff;
        for (int i = 0; i < SET_W; i++)
        begin
            set_idx[i] = shifted[i] && (i < int'(sb_eff));
        end
        tag_val = req.address >> (5'(off_eff) + sb_eff);
        if (ways_reg == 5'd0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_reg);
        end
    end

    // ---------------- control ----------------
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        retire     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = set_reg;
        ram_wdata  = row_new;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == SET_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // hold until the result slot is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    retire     = 1'b1;
                    ram_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            reads_reg     <= '0;
            writes_reg    <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (retire)
            begin
                rsp_valid_reg <= 1'b1;
                if (wr_reg && writes_reg != '1)
                begin
                    writes_reg <= writes_reg + 1'b1;
                end
                if (res.hit)
                begin
                    if (hits_reg != '1)
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                end
                else
                begin
                    if (reads_reg != '1)
                    begin
                        reads_reg <= reads_reg + 1'b1;
                    end
                    if (misses_reg != '1)
                    begin
                        misses_reg <= misses_reg + 1'b1;
                    end
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= set_idx;
            tag_reg <= tag_val;
            wr_reg  <= req.is_write;
        end
        if (retire)
        begin
            res_reg <= res;
        end
    end

    // ---------------- tag RAM and set logic ----------------
    sactc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    sactc_set_logic #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_set (
        .row_in        (ram_rdata),
        .tag           (tag_reg),
        .ways          (ways_eff),
        .policy_is_lru (policy_reg),
        .row_out       (row_new),
        .res           (res)
    );

    // ---------------- result ----------------
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = res_reg.hit;
    assign rsp.way_used      = res_reg.way_used;
    assign rsp.evicted       = res_reg.evicted;
    assign rsp.memory_reads  = reads_reg;
    assign rsp.memory_writes = writes_reg;
    assign rsp.hit_count     = hits_reg;
    assign rsp.miss_count    = misses_reg;

    // ---------------- checks ----------------
    `ASSERT_CLK(a_accept_to_update, clk, rst_n, accept |=> state_reg == S_UPDATE)
    `ASSERT_NEVER(a_no_accept_clear, clk, rst_n, state_reg == S_CLEAR && req.ready)
    `ASSERT_NEVER(a_hit_evict, clk, rst_n, rsp_valid_reg && res_reg.hit && res_reg.evicted)
    `ASSERT_CLK(a_write_source, clk, rst_n,
                ram_we |-> (state_reg == S_CLEAR || state_reg == S_UPDATE))
endmodule
